FILE: design/pfre_pkg.sv
// Shared types and constants for the page framebuffer refresh engine.
package pfre_pkg;

  localparam logic [2:0] OP_DRAW  = 3'd0;
  localparam logic [2:0] OP_PLOT  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // position within a page: three command bytes, then data
  localparam logic [1:0] HDR_PAGE = 2'd0;
  localparam logic [1:0] HDR_LOW  = 2'd1;
  localparam logic [1:0] HDR_HIGH = 2'd2;
  localparam logic [1:0] HDR_DATA = 2'd3;

  typedef enum logic [1:0] {
    K_WRITE,
    K_CLEAR,
    K_START,
    K_TICK
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       set;
    logic [7:0] mask;
  } pfre_op_t;

endpackage

FILE: design/pfre_front.sv
// Front end: accepts input items, range-checks them and turns them into store commands.
module pfre_front
  import pfre_pkg::*;
#(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128,
  parameter int AW      = 10
) (
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,
  input  logic          init_busy,
  input  logic          q_ready,
  output logic          q_push,
  output pfre_op_t      q_op,
  output logic [AW-1:0] q_addr
);

  localparam int ROWS = PAGES * 8;

  logic [2:0]  op;
  logic [7:0]  column;
  logic [7:0]  row;
  logic        lit;
  logic [15:0] level;
  logic [6:0]  height;
  logic [4:0]  pg;
  logic [2:0]  bit_sel;
  logic [15:0] addr_wide;
  logic        keep;
  logic        col_ok;

  assign op     = s_tdata[2:0];
  assign column = s_tdata[10:3];
  assign row    = s_tdata[18:11];
  assign lit    = s_tdata[19];
  assign level  = s_tdata[35:20];

  assign s_tready = q_ready && !init_busy && !rst;
  assign col_ok   = {1'b0, column} < 9'(COLUMNS);
  assign height   = (level > 16'(ROWS - 1)) ? 7'(ROWS - 1) : level[6:0];

  always_comb begin
    keep      = 1'b0;
    q_op.kind = K_TICK;
    q_op.set  = 1'b1;
    pg        = 5'd0;
    bit_sel   = 3'd0;
    unique case (op)
      OP_DRAW: begin
        keep      = col_ok && ({1'b0, row} < 9'(ROWS));
        q_op.kind = K_WRITE;
        q_op.set  = lit;
        pg        = row[7:3];
        bit_sel   = row[2:0];
      end
      OP_PLOT: begin
        keep      = col_ok;
        q_op.kind = K_WRITE;
        pg        = {1'b0, height[6:3]};
        bit_sel   = height[2:0];
      end
      OP_CLEAR: begin
        keep      = 1'b1;
        q_op.kind = K_CLEAR;
      end
      OP_START: begin
        keep      = 1'b1;
        q_op.kind = K_START;
      end
      OP_TICK: begin
        keep      = 1'b1;
        q_op.kind = K_TICK;
      end
      default: keep = 1'b0;
    endcase
    q_op.mask = 8'b1 << bit_sel;
  end

  assign addr_wide = {11'd0, pg} * 16'(COLUMNS) + {8'd0, column};
  assign q_addr    = addr_wide[AW-1:0];
  assign q_push    = s_tvalid && s_tready && keep;

endmodule

FILE: design/pfre_queue.sv
// Two-entry command queue between the front end and the store engine.
module pfre_queue #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign ready   = count != 2'd2;
  assign valid   = count != 2'd0;
  assign dout    = slots[rptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: design/pfre_back.sv
// Back end: pixel store, clear sweep and refresh stream sequencer.
module pfre_back
  import pfre_pkg::*;
#(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128,
  parameter int AW      = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pfre_op_t      q_op,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  output logic          init_busy,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tuser,
  output logic          m_tlast
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RMW,
    S_CLEAR,
    S_TICK
  } state_t;

  state_t        state;
  logic [AW-1:0] sweep;
  logic          active;
  logic [PW-1:0] page;
  logic [1:0]    hdr;
  logic [CW-1:0] col;
  logic [AW-1:0] daddr;
  logic          tick_last;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic          wr_set;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  logic          slot_free;
  logic          load_cmd;
  logic          load_data;
  logic [7:0]    cmd_byte;
  logic          col_end;
  logic          page_end;

  assign slot_free = !m_tvalid || m_tready;
  assign init_busy = state == S_INIT;
  assign col_end   = col == CW'(COLUMNS - 1);
  assign page_end  = page == PW'(PAGES - 1);
  assign load_data = (state == S_TICK) && slot_free;

  always_comb begin
    unique case (hdr)
      HDR_PAGE: cmd_byte = CMD_PAGE_BASE + 8'(page);
      HDR_LOW:  cmd_byte = CMD_COL_LOW;
      HDR_HIGH: cmd_byte = CMD_COL_HIGH;
      default:  cmd_byte = CMD_COL_LOW;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    re       = 1'b0;
    raddr    = q_addr;
    we       = 1'b0;
    waddr    = sweep;
    wdata    = 8'd0;
    load_cmd = 1'b0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            K_WRITE: begin
              q_pop = 1'b1;
              re    = 1'b1;
            end
            K_CLEAR, K_START: q_pop = 1'b1;
            K_TICK: begin
              if (!active) begin
                q_pop = 1'b1;
              end else if (hdr != HDR_DATA) begin
                q_pop    = slot_free;
                load_cmd = slot_free;
              end else begin
                q_pop = 1'b1;
                re    = 1'b1;
                raddr = daddr;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_RMW: begin
        we    = 1'b1;
        waddr = wr_addr;
        wdata = wr_set ? (rdata | wr_mask) : (rdata & ~wr_mask);
      end
      S_TICK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sweep    <= '0;
      active   <= 1'b0;
      page     <= '0;
      hdr      <= HDR_PAGE;
      col      <= '0;
      daddr    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_cmd || load_data) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_op.kind)
              K_WRITE: begin
                wr_addr <= q_addr;
                wr_mask <= q_op.mask;
                wr_set  <= q_op.set;
                state   <= S_RMW;
              end
              K_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              K_START: begin
                active <= 1'b1;
                page   <= '0;
                hdr    <= HDR_PAGE;
                col    <= '0;
                daddr  <= '0;
              end
              K_TICK: begin
                if (load_cmd) begin
                  m_tdata  <= cmd_byte;
                  m_tuser  <= 1'b0;
                  m_tlast  <= 1'b0;
                  hdr      <= hdr + 2'd1;
                end else if (active && hdr == HDR_DATA) begin
                  state     <= S_TICK;
                  tick_last <= col_end && page_end;
                  daddr     <= daddr + 1'b1;
                  if (col_end) begin
                    col <= '0;
                    hdr <= HDR_PAGE;
                    if (page_end) begin
                      page   <= '0;
                      active <= 1'b0;
                      daddr  <= '0;
                    end else begin
                      page <= page + 1'b1;
                    end
                  end else begin
                    col <= col + 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RMW: state <= S_IDLE;
        S_TICK: begin
          if (load_data) begin
            m_tdata  <= rdata;
            m_tuser  <= 1'b1;
            m_tlast  <= tick_last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/page_framebuffer_refresh_engine.sv
// Page-mode monochrome framebuffer with refresh byte stream generator.
// Input items arrive on s_tvalid/s_tready/s_tdata: op selects draw_point,
// plot_sample, clear, start_refresh or tick. Out-of-range draws, unused op
// codes and ticks while no refresh runs produce nothing.
// Each tick during a refresh yields one item on m_*: per page the command
// bytes 0xB0+page, 0x00, 0x10, then COLUMNS data bytes (m_tuser = 1);
// m_tlast marks the final data byte of the frame.
// draw_point and plot_sample do a read-modify-write of the single store
// memory, a data tick waits for the registered memory read, command ticks
// and start_refresh need no store access; clear dispatches, then writes
// one store byte per cycle.
// A two-entry queue decouples acceptance.
// A command byte reaches m_tvalid through the queue and the output register;
// a data byte also passes through the registered memory read.
// After reset all PAGES*COLUMNS store bytes (1024 by default) are swept to
// zero, during which s_tready stays low.
// When the receiver stalls the output register holds its item; the engine
// waits and the queue fills before s_tready drops.
module page_framebuffer_refresh_engine
  import pfre_pkg::*;
#(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[2:0], column[10:3], row[18:11], lit[19], level[35:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tuser,   // is_data
  output logic        m_tlast
);

  localparam int AW = $clog2(PAGES * COLUMNS);
  localparam int QW = $bits(pfre_op_t) + AW;

  logic          init_busy;
  logic          q_push;
  logic          q_ready;
  pfre_op_t      push_op;
  logic [AW-1:0] push_addr;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_dout;
  pfre_op_t      head_op;
  logic [AW-1:0] head_addr;

  pfre_front #(.PAGES(PAGES), .COLUMNS(COLUMNS), .AW(AW)) u_front (
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .init_busy (init_busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_op      (push_op),
    .q_addr    (push_addr)
  );

  pfre_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({push_op, push_addr}),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign head_op   = q_dout[QW-1:AW];
  assign head_addr = q_dout[AW-1:0];

  pfre_back #(.PAGES(PAGES), .COLUMNS(COLUMNS), .AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_addr    (head_addr),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // end of frame is always a data byte
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("frame end flagged on a command byte");

  // command bytes are only the page and column address codes
  a_cmd_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      (m_tdata == CMD_COL_LOW) || (m_tdata == CMD_COL_HIGH) || (m_tdata[7:4] == 4'hB))
    else $error("unexpected command byte");

  // nothing is taken in while the store is being swept after reset
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !s_tready)
    else $error("input accepted during store initialization");

endmodule

FILE: tb/sv/tb_page_framebuffer_refresh_engine.sv
// Testbench for the page framebuffer refresh engine: stream driver, predictor, checker.
`timescale 1ns / 1ps

module tb_page_framebuffer_refresh_engine;
  import pfre_pkg::*;

  localparam int NPAGES      = 8;
  localparam int NCOLS       = 128;
  localparam int NROWS       = NPAGES * 8;
  localparam int HDR_BYTES   = 3;
  localparam int FRAME_TICKS = NPAGES * (HDR_BYTES + NCOLS);
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT_A   = 120;
  localparam int HOLD_AT_B   = 700;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  // op codes the block does not decode
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  column;
    logic [7:0]  row;
    logic        lit;
    logic [15:0] level;
    logic        drain_first;  // hold this item until every byte has come back
  } op_item_t;

  typedef struct packed {
    logic [7:0] val;
    logic       is_data;
    logic       last;
  } frame_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // op[2:0], column[10:3], row[18:11], lit[19], level[35:20]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // out_byte[7:0]
  logic        m_tuser;       // is_data
  logic        m_tlast;

  page_framebuffer_refresh_engine dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the display store and the frame walker
  logic [7:0]  shadow_pixels [0:NPAGES*NCOLS-1];
  logic        frame_running = 1'b0;
  int          frame_page = 0;
  int          frame_pos = 0;

  op_item_t    pending_ops [$];
  frame_byte_t expected_bytes [$];
  op_item_t    in_flight;
  op_item_t    next_op;
  int          send_gap = 0;
  bit          send_busy = 1'b1;
  int          recv_gap = 0;
  int          hold_left = 0;
  bit          recv_busy = 1'b1;
  int          bytes_seen = 0;
  int          fault_count = 0;
  int          cycle_count = 0;
  frame_byte_t want;

  initial begin
    foreach (shadow_pixels[i]) shadow_pixels[i] = 8'h00;
  end

  function automatic void predict_refresh(input op_item_t it);
    int          idx;
    logic [5:0]  h;
    frame_byte_t fb;
    case (it.op)
      OP_DRAW: begin
        if (int'(it.column) < NCOLS && int'(it.row) < NROWS) begin
          idx = int'(it.row[5:3]) * NCOLS + int'(it.column);
          shadow_pixels[idx][it.row[2:0]] = it.lit;
        end
      end
      OP_PLOT: begin
        if (int'(it.column) < NCOLS) begin
          h = (int'(it.level) > NROWS - 1) ? 6'(NROWS - 1) : it.level[5:0];
          idx = int'(h[5:3]) * NCOLS + int'(it.column);
          shadow_pixels[idx][h[2:0]] = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (shadow_pixels[i]) shadow_pixels[i] = 8'h00;
      end
      OP_START: begin
        frame_running = 1'b1;
        frame_page = 0;
        frame_pos = 0;
      end
      OP_TICK: begin
        if (frame_running) begin
          fb.is_data = 1'b0;
          fb.last = 1'b0;
          if (frame_pos == int'(HDR_PAGE)) begin
            fb.val = CMD_PAGE_BASE + 8'(frame_page);
            frame_pos++;
          end else if (frame_pos == int'(HDR_LOW)) begin
            fb.val = CMD_COL_LOW;
            frame_pos++;
          end else if (frame_pos == int'(HDR_HIGH)) begin
            fb.val = CMD_COL_HIGH;
            frame_pos++;
          end else begin
            idx = frame_pos - HDR_BYTES;
            fb.val = shadow_pixels[frame_page * NCOLS + idx];
            fb.is_data = 1'b1;
            if (idx == NCOLS - 1) begin
              frame_pos = 0;
              if (frame_page == NPAGES - 1) begin
                frame_page = 0;
                frame_running = 1'b0;
                fb.last = 1'b1;
              end else begin
                frame_page++;
              end
            end else begin
              frame_pos++;
            end
          end
          expected_bytes.push_back(fb);
        end
      end
      default: ;
    endcase
  endfunction

  // random fields, mostly in range, sometimes past the pixel limits
  function automatic op_item_t random_fields(input logic [2:0] op);
    op_item_t it;
    it.op = op;
    it.column = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                              : 8'($urandom_range(0, 127));
    it.row = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(64, 255))
                                           : 8'($urandom_range(0, 63));
    it.lit = 1'($urandom_range(0, 1));
    it.level = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
    it.drain_first = 1'b0;
    return it;
  endfunction

  task automatic push_op(input logic [2:0] op, input logic [7:0] column,
                         input logic [7:0] row, input logic lit, input logic [15:0] level);
    op_item_t it;
    it = '{op: op, column: column, row: row, lit: lit, level: level, drain_first: 1'b0};
    pending_ops.push_back(it);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_refresh(in_flight);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain_first && expected_bytes.size() != 0)) begin
          next_op = pending_ops.pop_front();
          in_flight <= next_op;
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, next_op.level, next_op.lit, next_op.row, next_op.column, next_op.op};
          if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
          send_gap <= send_busy ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected item %0d: byte %02h data %0b last %0b",
                     bytes_seen, m_tdata, m_tuser, m_tlast);
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.val || m_tuser !== want.is_data || m_tlast !== want.last) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch item %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                       bytes_seen, want.val, want.is_data, want.last,
                       m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= (hold_left == 1);
      end else if (m_tvalid && m_tready && (bytes_seen == HOLD_AT_A || bytes_seen == HOLD_AT_B)) begin
        // long stall so the input queue backs up
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 39) == 0) recv_busy = !recv_busy;
        if (recv_busy) begin
          recv_gap <= $urandom_range(0, MAX_GAP);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= (recv_gap == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    op_item_t it;
    int       ticks_done;
    int       r;

    // directed: idle tick, spare codes, pixel extremes, edits, restarts and a clear mid-frame
    push_op(OP_TICK, 8'd0, 8'd0, 1'b0, 16'd0);
    for (int c = int'(OP_SPARE_LO); c <= int'(OP_SPARE_HI); c++)
      push_op(3'(c), 8'd255, 8'd255, 1'b1, 16'hFFFF);
    push_op(OP_DRAW, 8'd0, 8'd0, 1'b1, 16'd0);
    push_op(OP_DRAW, 8'd127, 8'd63, 1'b1, 16'd0);
    push_op(OP_DRAW, 8'd128, 8'd5, 1'b1, 16'd0);
    push_op(OP_DRAW, 8'd5, 8'd64, 1'b1, 16'd0);
    push_op(OP_DRAW, 8'd255, 8'd255, 1'b1, 16'd0);
    push_op(OP_DRAW, 8'd127, 8'd63, 1'b0, 16'd0);
    push_op(OP_DRAW, 8'd127, 8'd63, 1'b1, 16'd0);
    push_op(OP_PLOT, 8'd0, 8'd0, 1'b0, 16'd0);
    push_op(OP_PLOT, 8'd127, 8'd0, 1'b0, 16'hFFFF);
    push_op(OP_PLOT, 8'd200, 8'd0, 1'b0, 16'd3);
    push_op(OP_PLOT, 8'd64, 8'd0, 1'b0, 16'd64);
    push_op(OP_START, 8'd0, 8'd0, 1'b0, 16'd0);
    repeat (5) push_op(OP_TICK, 8'd0, 8'd0, 1'b0, 16'd0);
    push_op(OP_DRAW, 8'd2, 8'd0, 1'b1, 16'd0);  // column 2 not yet sent
    push_op(OP_TICK, 8'd0, 8'd0, 1'b0, 16'd0);
    push_op(OP_START, 8'd0, 8'd0, 1'b0, 16'd0);
    push_op(OP_TICK, 8'd0, 8'd0, 1'b0, 16'd0);
    push_op(OP_CLEAR, 8'd0, 8'd0, 1'b0, 16'd0);
    repeat (2) push_op(OP_TICK, 8'd0, 8'd0, 1'b0, 16'd0);

    // one full frame with edits folded in
    it = random_fields(OP_START);
    it.drain_first = 1'b1;
    pending_ops.push_back(it);
    ticks_done = 0;
    while (ticks_done < FRAME_TICKS) begin
      r = $urandom_range(0, 999);
      if (r < 940) begin
        it = random_fields(OP_TICK);
        ticks_done++;
      end else if (r < 970) it = random_fields(OP_DRAW);
      else if (r < 995) it = random_fields(OP_PLOT);
      else if (r < 997) it = random_fields(OP_CLEAR);
      else it = random_fields(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
      pending_ops.push_back(it);
    end

    // mixed traffic: restarts, ticks, draws, plots, clears and spare codes
    for (int n = 0; n < 80; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) it = random_fields(OP_START);
      else if (r < 58) it = random_fields(OP_TICK);
      else if (r < 78) it = random_fields(OP_DRAW);
      else if (r < 90) it = random_fields(OP_PLOT);
      else if (r < 92) it = random_fields(OP_CLEAR);
      else if (r < 95) it = random_fields(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
      else it = random_fields(OP_TICK);
      it.drain_first = (n % 40 == 0);
      pending_ops.push_back(it);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
